/* sv/acwa_pkg.sv */
// Shared types, constants and helpers for the adaptive clamp window average block.
package acwa_pkg;

   // Default ring depth
   localparam int unsigned DEPTH_DEF = 16;

   // Scale register widths (Q1.16 and Q4.16)
   localparam int unsigned LOW_SCALE_W  = 17;
   localparam int unsigned HIGH_SCALE_W = 20;

   // Reset value of both scales: 1.0 in Q.16
   localparam logic [HIGH_SCALE_W-1:0] SCALE_ONE = HIGH_SCALE_W'(65536);

   // Width of the signed border products (8-bit sample times 20-bit scale)
   localparam int unsigned PROD_W = 29;

   // Configuration bus
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (paddr[2])
   localparam logic REG_LOW_SCALE  = 1'b0;
   localparam logic REG_HIGH_SCALE = 1'b1;

   typedef enum logic [1:0] {
      OP_FILTER  = 2'd0,
      OP_PRELOAD = 2'd1,
      OP_SETTLE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_LOWER  = 2'd1,
      KIND_UPPER  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MULT,
      ST_DECIDE,
      ST_WRITE,
      ST_DIV,
      ST_OUT
   } state_type;

   // Round a Q.16 value half away from zero, saturate to signed 8 bits
   function automatic logic signed [7:0] round_sat_q16(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] sum;
      logic [PROD_W-17:0] r;
      logic signed [7:0] res;
      mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      sum = mag + PROD_W'(32768);
      r   = sum[PROD_W-1:16];
      if (v[PROD_W-1]) begin
         if (r >= (PROD_W-16)'(128)) begin
            res = -8'sd128;
         end else begin
            res = 8'(-r[7:0]);
         end
      end else begin
         if (r >= (PROD_W-16)'(127)) begin
            res = 8'sd127;
         end else begin
            res = 8'(r[7:0]);
         end
      end
      return res;
   endfunction

endpackage

/* sv/acwa_if.sv */
// Request and response channel interfaces (valid/ready transfer).
interface acwa_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic signed [7:0] sample;

   modport source (output valid, output operation, output sample, input ready);
   modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface acwa_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] average;
   logic [1:0]        clamp_kind;

   modport source (output valid, output average, output clamp_kind, input ready);
   modport sink   (input valid, input average, input clamp_kind, output ready);
endinterface

/* sv/acwa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module acwa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/acwa_div.sv */
// Constant divider by reciprocal multiplication; done follows start through a pending register and a done register.
module acwa_div #(
   parameter int unsigned DVD_W   = 14,
   parameter int unsigned DIVISOR = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   // floor(x / DIVISOR) == (x * RECIP) >> SHIFT for every x below 2^DVD_W
   localparam int unsigned SHIFT     = DVD_W + $clog2(DIVISOR);
   localparam int unsigned RECIP_W   = DVD_W + 2;
   localparam int unsigned PRODUCT_W = DVD_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

   logic                 pend_ff, pend_in;
   logic                 done_ff, done_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [PRODUCT_W-1:0] product;

   // Capture the dividend, then multiply by the reciprocal and shift
   always_comb begin
      pend_in = start;
      done_in = pend_ff;
      dvd_in  = start ? dividend : dvd_ff;
      product = PRODUCT_W'(dvd_ff) * PRODUCT_W'(RECIP);
      quo_in  = pend_ff ? DVD_W'(product >> SHIFT) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/adaptive_clamp_window_average.sv */
// Top level: sample ring in RAM, scan sequencer, border clamp and averaging.
//
//  channel | direction | transfer condition        | payload
//  --------+-----------+---------------------------+----------------------------
//  req_ch  | in        | valid && ready            | operation[1:0], sample[7:0]
//  rsp_ch  | out       | valid && ready            | average[7:0], clamp_kind[1:0]
//  csr     | in (APB)  | psel && penable && pwrite | low_scale @0x0, high_scale @0x4
//
// Preload and the unused code are handled in ST_IDLE. A filter request runs DEPTH RAM
// reads, drain, multiply, clamp, write back, a reciprocal divide by DEPTH and the output
// load, then returns to idle. Settle runs the scan, drain and a rounded divide, then
// writes the mean into the ring. Reset clears the ring through per-entry valid bits; no
// clearing pass is needed. A finished result sits in the output register while the next
// request is taken; a new filter result waits only if that register is full.
module adaptive_clamp_window_average #(
   parameter int unsigned DEPTH = acwa_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   acwa_req_if.sink                            req_ch,
   acwa_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [acwa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [acwa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [acwa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import acwa_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned MAG_W = $clog2(128 * DEPTH) + 1;
   localparam int unsigned SUM_W = MAG_W + 1;
   localparam int unsigned DVD_W = MAG_W + 2;

   // Control
   state_type               state_ff, state_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [PTR_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [1:0]              op_ff, op_in;
   logic signed [7:0]       samp_ff, samp_in;
   logic [PTR_W-1:0]        rd_idx_ff, rd_idx_in;
   logic signed [7:0]       mn_ff, mn_in;
   logic signed [7:0]       mx_ff, mx_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [7:0]       old_ff, old_in;
   logic signed [PROD_W-1:0] lo_ff, lo_in;
   logic signed [PROD_W-1:0] hi_ff, hi_in;
   logic signed [7:0]       new_ff, new_in;
   logic [1:0]              kind_ff, kind_in;
   logic                    div_neg_ff, div_neg_in;
   logic signed [7:0]       avg_ff, avg_in;
   logic signed [7:0]       rsp_avg_ff, rsp_avg_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [LOW_SCALE_W-1:0]  low_scale_ff, low_scale_in;
   logic [HIGH_SCALE_W-1:0] high_scale_ff, high_scale_in;

   // RAM and divider hookup
   logic                    mem_we;
   logic [PTR_W-1:0]        mem_waddr;
   logic [7:0]              mem_wdata;
   logic [7:0]              mem_rdata;
   logic                    div_start;
   logic [DVD_W-1:0]        div_dvd;
   logic                    div_done;
   logic [DVD_W-1:0]        div_quo;

   // Scratch
   logic                    req_xfer;
   logic signed [7:0]       entry;
   logic signed [SUM_W-1:0] sum_new;
   logic signed [SUM_W-1:0] sum_abs;
   logic [MAG_W-1:0]        mag;
   logic signed [PROD_W-1:0] sq;
   logic [7:0]              q8;
   logic signed [7:0]       div_val;
   logic [PTR_W-1:0]        ptr_next;

   acwa_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (scan_idx_ff),
      .rd_data (mem_rdata)
   );

   acwa_div #(
      .DVD_W   (DVD_W),
      .DIVISOR (2 * DEPTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .done     (div_done),
      .quotient (div_quo)
   );

   // APB register file
   assign pready = 1'b1;

   always_comb begin
      low_scale_in  = low_scale_ff;
      high_scale_in = high_scale_ff;
      if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_LOW_SCALE:  low_scale_in  = pwdata[LOW_SCALE_W-1:0];
            REG_HIGH_SCALE: high_scale_in = pwdata[HIGH_SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LOW_SCALE:  prdata = CSR_DATA_W'(low_scale_ff);
         REG_HIGH_SCALE: prdata = CSR_DATA_W'(high_scale_ff);
         default:        prdata = '0;
      endcase
   end

   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign ptr_next = (ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
   assign entry    = valid_ff[rd_idx_ff] ? $signed(mem_rdata) : 8'sd0;
   assign sq       = {{(PROD_W-24){samp_ff[7]}}, samp_ff, 16'h0000};
   assign sum_new  = sum_ff - {{(SUM_W-8){old_ff[7]}}, old_ff}
                            + {{(SUM_W-8){new_ff[7]}}, new_ff};
   assign q8       = div_quo[7:0];
   assign div_val  = div_neg_ff ? $signed(8'(-q8)) : $signed(q8);

   // Sequencer: next state, RAM and divider control
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      valid_in     = valid_ff;
      scan_idx_in  = scan_idx_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = scan_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      samp_in      = samp_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      sum_in       = sum_ff;
      old_in       = old_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      new_in       = new_ff;
      kind_in      = kind_ff;
      div_neg_in   = div_neg_ff;
      avg_in       = avg_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_kind_in  = rsp_kind_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = samp_ff;
      div_start    = 1'b0;
      div_dvd      = '0;
      sum_abs      = '0;
      mag          = '0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Fold in read data returning from the scan
      if (rd_vld_ff) begin
         if (entry < mn_ff) begin
            mn_in = entry;
         end
         if (entry > mx_ff) begin
            mx_in = entry;
         end
         sum_in = sum_ff + {{(SUM_W-8){entry[7]}}, entry};
         if (rd_idx_ff == ptr_ff) begin
            old_in = entry;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in   = req_ch.operation;
               samp_in = req_ch.sample;
               case (req_ch.operation)
                  OP_PRELOAD: begin
                     mem_we            = 1'b1;
                     mem_wdata         = req_ch.sample;
                     valid_in[ptr_ff]  = 1'b1;
                     ptr_in            = ptr_next;
                  end
                  OP_FILTER, OP_SETTLE: begin
                     mn_in       = 8'sd127;
                     mx_in       = -8'sd128;
                     sum_in      = '0;
                     old_in      = '0;
                     scan_idx_in = '0;
                     state_in    = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (scan_idx_ff == PTR_W'(DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + PTR_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            if (op_ff == OP_SETTLE) begin
               // Rounded mean: (2|sum| + DEPTH) / (2 DEPTH)
               sum_abs    = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
               mag        = sum_abs[MAG_W-1:0];
               div_start  = 1'b1;
               div_dvd    = DVD_W'({mag, 1'b0}) + DVD_W'(DEPTH);
               div_neg_in = sum_ff[SUM_W-1];
               state_in   = ST_DIV;
            end else begin
               lo_in    = PROD_W'($signed({{(PROD_W-8){mn_ff[7]}}, mn_ff})
                                * $signed({{(PROD_W-LOW_SCALE_W){1'b0}}, low_scale_ff}));
               hi_in    = PROD_W'($signed({{(PROD_W-8){mx_ff[7]}}, mx_ff})
                                * $signed({{(PROD_W-HIGH_SCALE_W){1'b0}}, high_scale_ff}));
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // Lower border is tested first
            if (sq >= lo_ff) begin
               new_in  = round_sat_q16(lo_ff);
               kind_in = KIND_LOWER;
            end else if (sq <= hi_ff) begin
               new_in  = round_sat_q16(hi_ff);
               kind_in = KIND_UPPER;
            end else begin
               new_in  = samp_ff;
               kind_in = KIND_SAMPLE;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // Truncated mean: 2|sum| / (2 DEPTH)
            mem_we           = 1'b1;
            mem_wdata        = new_ff;
            valid_in[ptr_ff] = 1'b1;
            ptr_in           = ptr_next;
            sum_abs          = sum_new[SUM_W-1] ? -sum_new : sum_new;
            mag              = sum_abs[MAG_W-1:0];
            div_start        = 1'b1;
            div_dvd          = DVD_W'({mag, 1'b0});
            div_neg_in       = sum_new[SUM_W-1];
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (op_ff == OP_SETTLE) begin
                  mem_we           = 1'b1;
                  mem_wdata        = div_val;
                  valid_in[ptr_ff] = 1'b1;
                  ptr_in           = ptr_next;
                  state_in         = ST_IDLE;
               end else begin
                  avg_in   = div_val;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_kind_in  = kind_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         valid_ff      <= '0;
         scan_idx_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         low_scale_ff  <= SCALE_ONE[LOW_SCALE_W-1:0];
         high_scale_ff <= SCALE_ONE;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         valid_ff      <= valid_in;
         scan_idx_ff   <= scan_idx_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         low_scale_ff  <= low_scale_in;
         high_scale_ff <= high_scale_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      samp_ff     <= samp_in;
      rd_idx_ff   <= rd_idx_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      sum_ff      <= sum_in;
      old_ff      <= old_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      new_ff      <= new_in;
      kind_ff     <= kind_in;
      div_neg_ff  <= div_neg_in;
      avg_ff      <= avg_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.average    = rsp_avg_ff;
   assign rsp_ch.clamp_kind = rsp_kind_ff;

   // Checks
   a_rsp_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response loaded outside output state");

   a_no_write_during_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !(state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("ring written while scan reads are in flight");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(DEPTH - 1))
      else $error("write pointer beyond ring depth");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

endmodule

/* sim/adaptive_clamp_window_average_tb.sv */
// Testbench: directed and random transfers checked against a window/clamp predictor.
`timescale 1ns / 1ps

module adaptive_clamp_window_average_tb;
   import acwa_pkg::*;

   localparam int RING_DEPTH     = DEPTH_DEF;
   localparam longint Q16_ONE    = 65536;
   localparam int PHASE_COUNT    = 11;
   localparam int PHASE_ITEMS    = 70;
   localparam int DRAIN_CYCLES   = 80;
   localparam int QUIET_LIMIT    = 4000;
   localparam int IDLE_PERCENT   = 18;
   localparam int STEADY_PHASE   = 3;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic signed [7:0] average;
      kind_type          kind;
   } window_result;

   typedef struct packed {
      logic [1:0]        op;
      logic signed [7:0] smp;
      bit                typed;
      logic signed [7:0] avg;
      kind_type          kind;
   } stim_row;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   acwa_req_if req_bus ();
   acwa_rsp_if rsp_bus ();

   adaptive_clamp_window_average uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: sample ring, write pointer and scale registers
   logic signed [7:0] ring [RING_DEPTH];
   logic [3:0]        ring_ptr;
   logic [16:0]       low_scale_q;
   logic [19:0]       high_scale_q;

   window_result expected_averages [$];
   int           mismatch_count = 0;
   bit           no_idle = 1'b0;

   // Directed rows; the first three run on the all-zero ring after reset
   stim_row directed_rows [20] = '{
      '{OP_FILTER,  8'sd0,    1'b1, 8'sd0, KIND_LOWER},  // zero equals lower border
      '{OP_FILTER,  8'h80,    1'b1, 8'sd0, KIND_UPPER},  // most negative sample
      '{OP_FILTER,  8'h7F,    1'b1, 8'sd0, KIND_LOWER},  // most positive sample
      '{OP_UNUSED,  8'hFF,    1'b0, 8'sd0, KIND_SAMPLE}, // unused code: no change
      '{OP_PRELOAD, 8'sd8,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_SETTLE,  8'sd0,    1'b0, 8'sd0, KIND_SAMPLE}, // mean of one half rounds up
      '{OP_FILTER,  8'hFF,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_PRELOAD, 8'h80,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_PRELOAD, 8'h7F,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_PRELOAD, 8'h80,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_SETTLE,  8'h55,    1'b0, 8'sd0, KIND_SAMPLE}, // sample field ignored
      '{OP_FILTER,  8'h7F,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_FILTER,  8'h80,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_PRELOAD, -8'sd70,  1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_PRELOAD, -8'sd72,  1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_FILTER,  -8'sd71,  1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_SETTLE,  8'hAA,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_FILTER,  8'sd1,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_UNUSED,  8'h00,    1'b0, 8'sd0, KIND_SAMPLE},
      '{OP_FILTER,  -8'sd40,  1'b0, 8'sd0, KIND_SAMPLE}
   };

   // Round a Q.16 border half away from zero, saturate to 8 bits
   function automatic logic signed [7:0] round_border(input longint v);
      longint mag;
      longint r;
      mag = (v < 0) ? -v : v;
      r = (mag + 32768) >>> 16;
      if (v < 0) begin
         return (r > 128) ? 8'h80 : 8'(-r);
      end
      return (r > 127) ? 8'h7F : 8'(r);
   endfunction

   function automatic int ring_sum();
      int total;
      total = 0;
      for (int i = 0; i < RING_DEPTH; i++) total += ring[i];
      return total;
   endfunction

   function automatic void ring_store(input logic signed [7:0] v);
      ring[ring_ptr] = v;
      ring_ptr = ring_ptr + 4'd1;
   endfunction

   // Apply one request to the ring; returns 1 when a result is due
   function automatic bit predict_window_step(input logic [1:0] op,
                                              input logic signed [7:0] smp,
                                              output window_result res);
      int total, mag, q;
      logic signed [7:0] mn, mx;
      longint lo, hi, sq;
      res.average = 8'sd0;
      res.kind = KIND_SAMPLE;
      case (op)
         OP_PRELOAD: begin
            ring_store(smp);
         end
         OP_SETTLE: begin
            total = ring_sum();
            mag = (total < 0) ? -total : total;
            q = (2 * mag + RING_DEPTH) / (2 * RING_DEPTH);
            ring_store((total < 0) ? 8'(-q) : 8'(q));
         end
         OP_FILTER: begin
            mn = ring[0];
            mx = ring[0];
            for (int i = 1; i < RING_DEPTH; i++) begin
               if (ring[i] < mn) mn = ring[i];
               if (ring[i] > mx) mx = ring[i];
            end
            lo = longint'(mn) * longint'(low_scale_q);
            hi = longint'(mx) * longint'(high_scale_q);
            sq = longint'(smp) * Q16_ONE;
            // lower border is tested first
            if (sq >= lo) begin
               ring_store(round_border(lo));
               res.kind = KIND_LOWER;
            end else if (sq <= hi) begin
               ring_store(round_border(hi));
               res.kind = KIND_UPPER;
            end else begin
               ring_store(smp);
               res.kind = KIND_SAMPLE;
            end
            res.average = 8'(ring_sum() / RING_DEPTH);
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Random sample: mostly dBm-like, some full range, some extremes
   function automatic logic signed [7:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 8'(-100 + int'($urandom_range(70)));
      if (r < 90) return 8'($urandom);
      case ($urandom_range(3))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'hFF;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [1:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 58) return OP_FILTER;
      if (r < 80) return OP_PRELOAD;
      if (r < 92) return OP_SETTLE;
      return OP_UNUSED;
   endfunction

   // One request transfer; valid is left high so back-to-back items never toggle it
   task automatic send_request(input logic [1:0] op, input logic signed [7:0] smp,
                               input bit typed, input logic signed [7:0] typed_avg,
                               input kind_type typed_kind);
      window_result predicted;
      window_result typed_result;
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.sample    <= smp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (predict_window_step(op, smp, predicted)) begin
         if (typed) begin
            typed_result.average = typed_avg;
            typed_result.kind = typed_kind;
            expected_averages.push_back(typed_result);
         end else begin
            expected_averages.push_back(predicted);
         end
      end
   endtask

   // Drop valid, wait for every result, then let a settle or preload finish
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task automatic write_register(input logic idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] stored;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == REG_LOW_SCALE) begin
         low_scale_q = value[16:0];
         stored = {15'd0, low_scale_q};
      end else begin
         high_scale_q = value[19:0];
         stored = {12'd0, high_scale_q};
      end
      // read-back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== stored) begin
         $error("prdata: expected %0h, actual %0h", stored, readback);
         mismatch_count++;
      end
      @(posedge clock);
   endtask

   // Receiver: random back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin : check_results
      window_result want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_averages.size() == 0) begin
            $error("unexpected result: average %0d, clamp_kind %0d",
                   rsp_bus.average, rsp_bus.clamp_kind);
            mismatch_count++;
         end else begin
            want = expected_averages.pop_front();
            if (rsp_bus.average !== want.average) begin
               $error("average: expected %0d, actual %0d", want.average, rsp_bus.average);
               mismatch_count++;
            end
            if (rsp_bus.clamp_kind !== want.kind) begin
               $error("clamp_kind: expected %0d, actual %0d", want.kind, rsp_bus.clamp_kind);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too long without any transfer or register access
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      int count;
      int base;
      logic [31:0] low_w, high_w;
      logic [1:0] op;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_FILTER;
      req_bus.sample    <= 8'sd0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = 8'sd0;
      ring_ptr     = 4'd0;
      low_scale_q  = 17'(SCALE_ONE);
      high_scale_q = SCALE_ONE;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset scales
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].smp, directed_rows[i].typed,
                      directed_rows[i].avg, directed_rows[i].kind);
      end
      drain_block();

      // random phases, one scale setting each
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin low_w = 32'd65536;    high_w = 32'd65536;   end
            1: begin low_w = 32'd0;        high_w = 32'd65536;   end
            2: begin low_w = 32'd65536;    high_w = 32'd1048575; end
            3: begin low_w = 32'd32768;    high_w = 32'd131072;  end
            4: begin low_w = 32'h0001_FFFF; high_w = 32'h000F_FFFF; end
            5: begin low_w = 32'h0001_FFFF; high_w = 32'd0;       end
            6: begin low_w = 32'd45875;    high_w = 32'd98304;   end
            7: begin low_w = 32'd0;        high_w = 32'd0;       end
            8, 9: begin
               low_w  = $urandom_range(65536);
               high_w = $urandom_range(1048575, 65536);
            end
            default: begin low_w = $urandom; high_w = $urandom; end
         endcase
         write_register(REG_LOW_SCALE, low_w);
         write_register(REG_HIGH_SCALE, high_w);
         no_idle = (p == STEADY_PHASE);

         count = 0;
         // often start from a near-uniform window so stored samples appear
         if ($urandom_range(1) == 1) begin
            base = -100 + int'($urandom_range(60));
            repeat (RING_DEPTH) begin
               send_request(OP_PRELOAD, 8'(base + int'($urandom_range(6)) - 3),
                            1'b0, 8'sd0, KIND_SAMPLE);
               count++;
            end
         end
         while (count < PHASE_ITEMS) begin
            op = pick_op();
            send_request(op, pick_sample(), 1'b0, 8'sd0, KIND_SAMPLE);
            if (op != OP_UNUSED) count++;
         end
         drain_block();
         no_idle = 1'b0;
      end

      if (mismatch_count == 0 && expected_averages.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
sv/acwa_pkg.sv
sv/acwa_if.sv
sv/acwa_ram.sv
sv/acwa_div.sv
sv/adaptive_clamp_window_average.sv
sim/adaptive_clamp_window_average_tb.sv
